@@ rtl/cfde_pkg.sv @@
// ----------------------------------------------------------------------------
// cfde_pkg
// Shared types and constants for the first-descent Collatz engine: value and
// digit widths of the serial datapath, field widths and the control states.
// ----------------------------------------------------------------------------
package cfde_pkg;

  // 128-bit walk values move through the datapath in 32-bit digits
  localparam int VAL_W     = 128;
  localparam int DIG_W     = 32;
  localparam int NDIG      = VAL_W / DIG_W;
  localparam int DIG_IDX_W = $clog2(NDIG);

  // field widths of the channel words
  localparam int MASK_W  = 28;
  localparam int DEPTH_W = 16;
  localparam int COUNT_W = 29;
  localparam int LIMIT_W = 16;
  localparam int HALF_W  = 64;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2000;

  typedef logic [DIG_W-1:0] digit_t;

  // engine control states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_STEP,
    ST_FLUSH,
    ST_FINISH
  } state_t;

endpackage

@@ rtl/cfde_if.sv @@
// ----------------------------------------------------------------------------
// cfde channel interfaces
// Valid/ready channels for the selector word going in and the result word
// coming out of the first-descent Collatz engine.
// ----------------------------------------------------------------------------
interface cfde_in_if;
  import cfde_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] selector_mask;

  modport source (output valid, output selector_mask, input ready);
  modport sink   (input valid, input selector_mask, output ready);
endinterface

interface cfde_out_if;
  import cfde_pkg::*;

  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] descent_depth;
  logic               overflowed;
  logic               no_descent;
  logic [DEPTH_W-1:0] best_depth;
  logic [MASK_W-1:0]  best_mask;
  logic [COUNT_W-1:0] failure_total;
  logic [COUNT_W-1:0] overflow_total;
  logic [HALF_W-1:0]  peak_upper;
  logic [HALF_W-1:0]  peak_lower;

  modport source (
    output valid, input ready,
    output descent_depth, output overflowed, output no_descent,
    output best_depth, output best_mask, output failure_total,
    output overflow_total, output peak_upper, output peak_lower
  );
  modport sink (
    input valid, output ready,
    input descent_depth, input overflowed, input no_descent,
    input best_depth, input best_mask, input failure_total,
    input overflow_total, input peak_upper, input peak_lower
  );
endinterface

@@ rtl/collatz_first_descent_engine_core.sv @@
// ----------------------------------------------------------------------------
// collatz_first_descent_engine_core
// Walks the shortcut Collatz map from a start value built out of a selector
// word and reports the first descent below the start, with running records.
// ----------------------------------------------------------------------------
// Each selector word builds N = 4*3^BASE_EXPONENT + 3 + 4*sum(3^i, bit i set)
// and then applies (3x+1)/2 or x/2 on 128 bits until the value drops below N,
// step_limit steps pass, or 3x+1 would not fit. The 128-bit walk, start and
// peak values sit in rotating rings of four 32-bit digits, and the 32-bit
// adder slices handle one digit per cycle. An item is accepted in the idle
// state, then takes P setup passes with P = max(SELECTOR_BITS, BASE_EXPONENT+1),
// one pass per Collatz step taken (an overflowing step counts as one), a peak
// flush pass and a finish state that waits for the output register to be free.
// A new word is taken while the previous result still waits in the output register.
module collatz_first_descent_engine_core #(
  parameter int SELECTOR_BITS = 28,
  parameter int BASE_EXPONENT = 44
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [cfde_pkg::LIMIT_W-1:0] cfg_wdata,
  cfde_in_if.sink                   work,
  cfde_out_if.source                result
);
  import cfde_pkg::*;

  // setup passes: one power of three per pass
  localparam int NPASS  = (SELECTOR_BITS > BASE_EXPONENT + 1) ? SELECTOR_BITS
                                                              : BASE_EXPONENT + 1;
  localparam int PASS_W = $clog2(NPASS);
  localparam logic [MASK_W-1:0] KEEP_MASK =
    (SELECTOR_BITS >= MASK_W) ? {MASK_W{1'b1}}
                              : MASK_W'((64'd1 << SELECTOR_BITS) - 64'd1);

  state_t state, state_next;

  logic [LIMIT_W-1:0]       step_limit;
  logic [DIG_IDX_W-1:0]     digit;
  logic [PASS_W-1:0]        pass_idx;
  logic [SELECTOR_BITS-1:0] sel;
  logic [MASK_W-1:0]        mask_keep;

  digit_t walk  [NDIG];
  digit_t start [NDIG];
  digit_t peak  [NDIG];

  logic carry;
  logic carry_p;
  logic p_msb;
  logic odd;
  logic lt_start;
  logic lt_peak;
  logic pending;

  logic [DEPTH_W-1:0] step_count;
  logic               ovf_flag;
  logic               desc_flag;

  logic [DEPTH_W-1:0] record_depth;
  logic [MASK_W-1:0]  record_selector;
  logic [COUNT_W-1:0] failure_count;
  logic [COUNT_W-1:0] overflow_count;

  logic               out_valid;
  logic [DEPTH_W-1:0] out_depth;
  logic               out_ovf;
  logic               out_nodesc;
  logic [DEPTH_W-1:0] out_best_depth;
  logic [MASK_W-1:0]  out_best_mask;
  logic [COUNT_W-1:0] out_fail;
  logic [COUNT_W-1:0] out_ovf_total;
  logic [VAL_W-1:0]   out_peak;

  // control decode
  logic in_ready;
  logic accept;
  logic run_setup;
  logic run_step;
  logic run_flush;
  logic finish_fire;

  logic first_dig;
  logic last_dig;
  logic last_pass;
  logic is_base;

  // setup slice
  digit_t             p_d;
  digit_t             p2_d;
  digit_t             addend;
  logic [DIG_W:0]     acc_sum;
  logic [DIG_W:0]     p3_sum;

  // step slice
  digit_t             x_d;
  digit_t             h_d;
  logic               od;
  logic [DIG_W:0]     y_sum;
  digit_t             y_d;
  digit_t             peak_eff;
  logic               lt_start_n;
  logic               lt_peak_n;
  logic               step_ovf;
  logic               step_stop;
  logic [DEPTH_W-1:0] step_count_inc;

  // finish values
  logic               fin_desc_better;
  logic [DEPTH_W-1:0] record_depth_next;
  logic [MASK_W-1:0]  record_selector_next;
  logic [COUNT_W-1:0] failure_count_next;
  logic [COUNT_W-1:0] overflow_count_next;

  // digit position within a pass
  assign first_dig = (digit == '0);
  assign last_dig  = (digit == DIG_IDX_W'(NDIG - 1));
  assign last_pass = (pass_idx == PASS_W'(NPASS - 1));
  assign is_base   = (pass_idx == PASS_W'(BASE_EXPONENT));

  // setup slice: acc += c*p, p *= 3, c is selector bit plus base flag
  always_comb begin
    p_d  = walk[0];
    p2_d = {p_d[DIG_W-2:0], (first_dig ? 1'b0 : p_msb)};
    if (sel[0] && is_base) begin
      addend = p2_d;
    end else if (sel[0] || is_base) begin
      addend = p_d;
    end else begin
      addend = '0;
    end
    acc_sum = {1'b0, start[0]} + {1'b0, addend} + (DIG_W+1)'(first_dig ? 1'b0 : carry);
    p3_sum  = {1'b0, p_d} + {1'b0, p2_d} + (DIG_W+1)'(first_dig ? 1'b0 : carry_p);
  end

  // step slice: odd x gives x + (x>>1) + 1, even x gives x>>1
  always_comb begin
    x_d      = walk[0];
    h_d      = {(last_dig ? 1'b0 : walk[1][0]), x_d[DIG_W-1:1]};
    od       = first_dig ? walk[0][0] : odd;
    y_sum    = {1'b0, (od ? x_d : '0)} + {1'b0, h_d}
             + (DIG_W+1)'(first_dig ? od : carry);
    y_d      = y_sum[DIG_W-1:0];
    peak_eff = pending ? x_d : peak[0];
    lt_start_n = (y_d < start[0]) ||
                 ((y_d == start[0]) && !first_dig && lt_start);
    lt_peak_n  = (peak_eff < y_d) ||
                 ((peak_eff == y_d) && !first_dig && lt_peak);
    step_ovf   = od && (y_sum[DIG_W] || y_sum[DIG_W-1]);
    step_count_inc = step_count + DEPTH_W'(1);
    step_stop  = step_ovf || lt_start_n || (step_count_inc == step_limit);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (work.valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        if (last_dig && last_pass) begin
          state_next = (step_limit == '0) ? ST_FLUSH : ST_STEP;
        end
      end
      ST_STEP: begin
        if (last_dig && step_stop) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (last_dig) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || result.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready    = 1'b0;
    run_setup   = 1'b0;
    run_step    = 1'b0;
    run_flush   = 1'b0;
    finish_fire = 1'b0;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_SETUP:  run_setup = 1'b1;
      ST_STEP:   run_step = 1'b1;
      ST_FLUSH:  run_flush = 1'b1;
      ST_FINISH: finish_fire = !out_valid || result.ready;
      default:   in_ready = 1'b0;
    endcase
  end

  assign accept     = in_ready && work.valid;
  assign work.ready = in_ready;

  // state register and step limit
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step_limit <= LIMIT_RESET;
    end else begin
      state <= state_next;
      if (cfg_wen) step_limit <= cfg_wdata;
    end
  end

  // digit and pass counters, item flags
  always_ff @(posedge clk) begin
    if (rst) begin
      digit      <= '0;
      pass_idx   <= '0;
      step_count <= '0;
      ovf_flag   <= 1'b0;
      desc_flag  <= 1'b0;
      pending    <= 1'b0;
    end else if (accept) begin
      digit      <= '0;
      pass_idx   <= '0;
      step_count <= '0;
      ovf_flag   <= 1'b0;
      desc_flag  <= 1'b0;
    end else begin
      if (run_setup || run_step || run_flush) digit <= digit + DIG_IDX_W'(1);
      if (run_setup && last_dig) pass_idx <= pass_idx + PASS_W'(1);
      if (run_step && last_dig) begin
        pending <= step_ovf ? 1'b0 : lt_peak_n;
        if (step_ovf) begin
          ovf_flag <= 1'b1;
        end else begin
          step_count <= step_count_inc;
          desc_flag  <= lt_start_n;
        end
      end
      if (run_flush && last_dig) pending <= 1'b0;
    end
  end

  // per-digit carries and running compares
  always_ff @(posedge clk) begin
    if (run_setup) begin
      carry   <= acc_sum[DIG_W];
      carry_p <= p3_sum[DIG_W];
      p_msb   <= p_d[DIG_W-1];
    end else if (run_step) begin
      carry    <= y_sum[DIG_W];
      lt_start <= lt_start_n;
      lt_peak  <= lt_peak_n;
      if (first_dig) odd <= walk[0][0];
    end
  end

  // selector shift register
  always_ff @(posedge clk) begin
    if (accept) begin
      sel       <= SELECTOR_BITS'(work.selector_mask);
      mask_keep <= work.selector_mask & KEEP_MASK;
    end else if (run_setup && last_dig) begin
      sel <= sel >> 1;
    end
  end

  // walk and start rings
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < NDIG; j++) begin
        walk[j]  <= (j == 0) ? DIG_W'(4) : '0;
        start[j] <= (j == 0) ? DIG_W'(3) : '0;
      end
    end else if (run_setup || run_step || run_flush) begin
      for (int j = 0; j < NDIG - 1; j++) begin
        walk[j]  <= walk[j+1];
        start[j] <= start[j+1];
      end
      if (run_setup) begin
        walk[NDIG-1]  <= last_pass ? acc_sum[DIG_W-1:0] : p3_sum[DIG_W-1:0];
        start[NDIG-1] <= acc_sum[DIG_W-1:0];
      end else if (run_step) begin
        walk[NDIG-1]  <= y_d;
        start[NDIG-1] <= start[0];
      end else begin
        walk[NDIG-1]  <= walk[0];
        start[NDIG-1] <= start[0];
      end
    end
  end

  // peak ring, takes the previous walk value when it was a new maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NDIG; j++) peak[j] <= '0;
    end else if (run_step || run_flush) begin
      for (int j = 0; j < NDIG - 1; j++) peak[j] <= peak[j+1];
      peak[NDIG-1] <= peak_eff;
    end
  end

  // record and counter updates at item end
  always_comb begin
    fin_desc_better      = desc_flag && (step_count > record_depth);
    record_depth_next    = fin_desc_better ? step_count : record_depth;
    record_selector_next = fin_desc_better ? mask_keep : record_selector;
    failure_count_next   = failure_count
                         + COUNT_W'(!ovf_flag && !desc_flag);
    overflow_count_next  = overflow_count + COUNT_W'(ovf_flag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_depth    <= '0;
      record_selector <= '0;
      failure_count   <= '0;
      overflow_count  <= '0;
    end else if (finish_fire) begin
      record_depth    <= record_depth_next;
      record_selector <= record_selector_next;
      failure_count   <= failure_count_next;
      overflow_count  <= overflow_count_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      out_depth      <= desc_flag ? step_count : '0;
      out_ovf        <= ovf_flag;
      out_nodesc     <= !ovf_flag && !desc_flag;
      out_best_depth <= record_depth_next;
      out_best_mask  <= record_selector_next;
      out_fail       <= failure_count_next;
      out_ovf_total  <= overflow_count_next;
      out_peak       <= {peak[3], peak[2], peak[1], peak[0]};
    end
  end

  assign result.valid          = out_valid;
  assign result.descent_depth  = out_depth;
  assign result.overflowed     = out_ovf;
  assign result.no_descent     = out_nodesc;
  assign result.best_depth     = out_best_depth;
  assign result.best_mask      = out_best_mask;
  assign result.failure_total  = out_fail;
  assign result.overflow_total = out_ovf_total;
  assign result.peak_upper     = out_peak[VAL_W-1:HALF_W];
  assign result.peak_lower     = out_peak[HALF_W-1:0];

endmodule

@@ sim/cfde_checker.sv @@
// ----------------------------------------------------------------------------
// cfde_checker
// Watches the selector and result channels of the first-descent Collatz
// engine. It walks every accepted selector word in 128-bit arithmetic, keeps
// its own copy of the running records and compares each result word field by
// field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cfde_checker #(
  parameter int SELECTOR_BITS = 28,
  parameter int BASE_EXPONENT = 44
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [cfde_pkg::LIMIT_W-1:0] cfg_wdata,
  cfde_in_if                           work,
  cfde_out_if                          result,
  output int                           mismatches,
  output int                           outstanding
);
  import cfde_pkg::*;

  // odd values above this bound no longer fit 3x+1 in 128 bits
  localparam logic [VAL_W-1:0] ODD_CEIL = {64'h5555555555555555, 64'h5555555555555554};

  typedef struct {
    logic [DEPTH_W-1:0] descent_depth;
    logic               overflowed;
    logic               no_descent;
    logic [DEPTH_W-1:0] best_depth;
    logic [MASK_W-1:0]  best_mask;
    logic [COUNT_W-1:0] failure_total;
    logic [COUNT_W-1:0] overflow_total;
    logic [HALF_W-1:0]  peak_upper;
    logic [HALF_W-1:0]  peak_lower;
  } walk_result_t;

  // running records, mirrored from the engine
  logic [VAL_W-1:0]   peak_seen;
  logic [DEPTH_W-1:0] record_depth;
  logic [MASK_W-1:0]  record_mask;
  logic [COUNT_W-1:0] fail_tally;
  logic [COUNT_W-1:0] ovf_tally;
  logic [LIMIT_W-1:0] step_limit;

  walk_result_t pending_results [$];
  walk_result_t oldest;
  int           words_seen;

  // build the start value, walk it and fold the outcome into the records
  function automatic walk_result_t walk_selector(input logic [MASK_W-1:0] sel);
    logic [VAL_W-1:0]   pw;
    logic [VAL_W-1:0]   start;
    logic [VAL_W-1:0]   x;
    logic [DEPTH_W-1:0] depth;
    logic               ovf;
    int                 i;
    int                 k;
    walk_result_t       r;
    pw = 1;
    for (i = 0; i < BASE_EXPONENT; i++) pw = pw * 3;
    start = (pw << 2) + 3;
    pw = 1;
    for (i = 0; i < SELECTOR_BITS; i++) begin
      if (i < MASK_W && sel[i]) start = start + (pw << 2);
      pw = pw * 3;
    end
    x = start;
    depth = '0;
    ovf = 1'b0;
    for (k = 1; k <= int'(step_limit); k++) begin
      if (x[0]) begin
        // the failing odd step produces no value
        if (x > ODD_CEIL) begin
          ovf = 1'b1;
          break;
        end
        x = (x * 3 + 1) >> 1;
      end else begin
        x = x >> 1;
      end
      if (x > peak_seen) peak_seen = x;
      if (x < start) begin
        depth = k[DEPTH_W-1:0];
        break;
      end
    end
    if (ovf) begin
      depth = '0;
      ovf_tally = ovf_tally + 1'b1;
    end else if (depth == 0) begin
      fail_tally = fail_tally + 1'b1;
    end else if (depth > record_depth) begin
      // ties leave the earlier record in place
      record_depth = depth;
      record_mask = sel;
    end
    r.descent_depth  = depth;
    r.overflowed     = ovf;
    r.no_descent     = !ovf && depth == 0;
    r.best_depth     = record_depth;
    r.best_mask      = record_mask;
    r.failure_total  = fail_tally;
    r.overflow_total = ovf_tally;
    r.peak_upper     = peak_seen[VAL_W-1:HALF_W];
    r.peak_lower     = peak_seen[HALF_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    $display("result word %0d: %s got %0h, want %0h", words_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [VAL_W-1:0] got,
                             input logic [VAL_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // compare before queueing, a word cannot leave in the cycle it enters
  always @(posedge clk) begin
    if (rst) begin
      peak_seen = '0;
      record_depth = '0;
      record_mask = '0;
      fail_tally = '0;
      ovf_tally = '0;
      step_limit = LIMIT_RESET;
      pending_results.delete();
      words_seen = 0;
      mismatches = 0;
    end else begin
      if (cfg_wen) step_limit = cfg_wdata;
      if (result.valid && result.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", '0, '0);
        end else begin
          oldest = pending_results.pop_front();
          check_field("descent_depth", VAL_W'(result.descent_depth),
                      VAL_W'(oldest.descent_depth));
          check_field("overflowed", VAL_W'(result.overflowed),
                      VAL_W'(oldest.overflowed));
          check_field("no_descent", VAL_W'(result.no_descent),
                      VAL_W'(oldest.no_descent));
          check_field("best_depth", VAL_W'(result.best_depth),
                      VAL_W'(oldest.best_depth));
          check_field("best_mask", VAL_W'(result.best_mask),
                      VAL_W'(oldest.best_mask));
          check_field("failure_total", VAL_W'(result.failure_total),
                      VAL_W'(oldest.failure_total));
          check_field("overflow_total", VAL_W'(result.overflow_total),
                      VAL_W'(oldest.overflow_total));
          check_field("peak_upper", VAL_W'(result.peak_upper),
                      VAL_W'(oldest.peak_upper));
          check_field("peak_lower", VAL_W'(result.peak_lower),
                      VAL_W'(oldest.peak_lower));
        end
        words_seen++;
      end
      if (work.valid && work.ready)
        pending_results = {pending_results, walk_selector(work.selector_mask)};
    end
    outstanding = pending_results.size();
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives selector words into the first-descent Collatz engine under several
// step limits, from directed corners to long random runs with random idling,
// a long result hold-off and sender pauses, and gives the final verdict from
// the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
  import cfde_pkg::*;

  localparam int CYCLE_LIMIT      = 30000000;
  localparam int HOLD_CYCLES      = 4000;
  localparam int PHASE_WORDS      = 200;
  localparam int SETTLE_CYCLES    = 40;
  localparam logic [MASK_W-1:0] MASK_ALL = '1;

  logic               clk;
  logic               rst;
  logic               cfg_wen;
  logic [LIMIT_W-1:0] cfg_wdata;
  int                 mismatches;
  int                 outstanding;
  int                 cycles;
  bit                 steady;
  int                 hold_asks;
  int                 hold_served;

  logic [MASK_W-1:0] corner_masks [8] = '{
    28'h0000000, 28'hFFFFFFF, 28'h0000001, 28'h8000000,
    28'h5555555, 28'hAAAAAAA, 28'h0000003, 28'hC000000
  };

  cfde_in_if  word_in ();
  cfde_out_if word_out ();

  collatz_first_descent_engine_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .work      (word_in),
    .result    (word_out)
  );

  cfde_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .work        (word_in),
    .result      (word_out),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // clock, period 4
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // mostly uniformly random masks, some with one bit set or one bit clear
  function automatic logic [MASK_W-1:0] rand_mask();
    logic [MASK_W-1:0] one_bit;
    one_bit = MASK_W'(1) << $urandom_range(MASK_W - 1);
    case ($urandom_range(9))
      0: return one_bit;
      1: return MASK_ALL ^ one_bit;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  // offer one selector word from a falling edge, return at the falling edge after it
  task automatic send_word(input logic [MASK_W-1:0] mask);
    while (!steady && $urandom_range(99) < 27) begin
      word_in.valid <= 1'b0;
      @(negedge clk);
    end
    word_in.valid <= 1'b1;
    word_in.selector_mask <= mask;
    @(posedge clk);
    while (!word_in.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and wait for every predicted word to come back
  task automatic drain();
    word_in.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] lim);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // one random run at a fixed step limit, paused halfway until all words are back
  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input bit calm, input bit hold);
    int n;
    set_limit(lim);
    steady = calm;
    for (n = 0; n < PHASE_WORDS; n++) begin
      if (hold && n == 5) hold_asks++;
      if (n == PHASE_WORDS / 2) drain();
      send_word(rand_mask());
    end
    steady = 1'b0;
  endtask

  // result side: random ready, or a long hold-off on request
  initial begin
    hold_served = 0;
    word_out.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_asks != hold_served) begin
        hold_served++;
        word_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        word_out.ready <= steady || ($urandom_range(99) >= 27);
        @(negedge clk);
      end
    end
  end

  // run guard
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = LIMIT_RESET;
    word_in.valid = 1'b0;
    word_in.selector_mask = '0;
    steady = 1'b0;
    hold_asks = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corner masks at the reset step limit
    foreach (corner_masks[j]) send_word(corner_masks[j]);
    // zero limit takes no step, every word fails
    set_limit('0);
    send_word(MASK_ALL);
    send_word(rand_mask());
    // a single step always climbs from an odd start
    set_limit(16'd1);
    send_word('0);
    send_word(rand_mask());
    set_limit('1);
    repeat (3) send_word(rand_mask());
    set_limit(16'd9);
    repeat (3) send_word(rand_mask());

    // random runs over several step limits
    run_phase(LIMIT_RESET, 1'b0, 1'b0);
    run_phase(LIMIT_W'($urandom_range(40, 1)), 1'b0, 1'b0);
    run_phase('1, 1'b0, 1'b0);
    run_phase(LIMIT_W'($urandom_range(65534, 41)), 1'b0, 1'b0);
    run_phase(LIMIT_RESET, 1'b1, 1'b0);
    run_phase(LIMIT_RESET, 1'b0, 1'b1);
    run_phase(LIMIT_W'($urandom_range(200, 2)), 1'b0, 1'b0);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
